/* design/lcpi_pkg.sv */
// shared types and constants of the capsule point interpolator
package lcpi_pkg;

   localparam int CAPSULE_BYTES      = 84;
   localparam int POINTS_PER_CAPSULE = 32;
   localparam int IDX_W              = $clog2(POINTS_PER_CAPSULE);
   localparam int CAB_W              = IDX_W - 1;
   localparam int POS_W              = 7;
   localparam int CAB_POS_W          = 3;
   localparam int Q6_W               = 15;
   localparam int DELTA_W            = 16;
   localparam int ANGLE_W            = 21;
   localparam int DIST_W             = 14;
   localparam int DATA_W             = 8;

   localparam logic [DELTA_W-1:0] FULL_TURN_Q6 = 16'd23040;
   localparam logic [ANGLE_W-1:0] FULL_TURN_U  = 21'd737280;
   localparam logic [ANGLE_W-1:0] HIGH_LIMIT_U = 21'd716800;
   localparam logic [ANGLE_W-1:0] LOW_LIMIT_U  = 21'd20480;

   localparam logic [3:0] SYNC0_NIBBLE = 4'hA;
   localparam logic [3:0] SYNC1_NIBBLE = 4'h5;

   // capsule header byte positions
   localparam logic [POS_W-1:0] POS_SYNC0    = 7'd0;
   localparam logic [POS_W-1:0] POS_SYNC1    = 7'd1;
   localparam logic [POS_W-1:0] POS_ANGLE_LO = 7'd2;
   localparam logic [POS_W-1:0] POS_ANGLE_HI = 7'd3;

   // byte slots inside a five-byte cabin
   localparam logic [CAB_POS_W-1:0] CAB_DIST0_LO = 3'd0;
   localparam logic [CAB_POS_W-1:0] CAB_DIST0_HI = 3'd1;
   localparam logic [CAB_POS_W-1:0] CAB_DIST1_LO = 3'd2;
   localparam logic [CAB_POS_W-1:0] CAB_DIST1_HI = 3'd3;
   localparam logic [CAB_POS_W-1:0] CAB_COMP     = 3'd4;

   localparam logic KIND_POINT    = 1'b0;
   localparam logic KIND_SYNC_ERR = 1'b1;

   typedef enum logic [1:0] {
      EMIT_IDLE,
      EMIT_DIFF,
      EMIT_RUN,
      EMIT_ERR
   } emit_state_type;

   typedef struct packed {
      logic            run;
      logic            err;
      logic [Q6_W-1:0] prev_angle;
      logic [Q6_W-1:0] cur_angle;
   } emit_req_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [DIST_W-1:0] data;
   } store_wr_type;

endpackage

/* design/lcpi_emitter.sv */
// distance store, angle accumulator sequencer and result register
module lcpi_emitter
   import lcpi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  emit_req_type       emit_req,
   input  store_wr_type       store_wr,
   output logic               busy,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_kind,
   output logic [ANGLE_W-1:0] rsp_point_angle,
   output logic [DIST_W-1:0]  rsp_point_distance,
   output logic               rsp_point_valid,
   output logic               rsp_revolution_start,
   output logic               rsp_last_of_run
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS_PER_CAPSULE - 1);

   emit_state_type state_ff, state_in;

   logic [DIST_W-1:0]  store_ff [POINTS_PER_CAPSULE];
   logic [DIST_W-1:0]  dist_rd_ff;
   logic [IDX_W-1:0]   rd_addr;

   logic [Q6_W-1:0]    p_ff, p_in;
   logic [Q6_W-1:0]    c_ff, c_in;
   logic [DELTA_W-1:0] d_ff, d_in;
   logic [ANGLE_W-1:0] acc_ff, acc_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [ANGLE_W-1:0] last_angle_ff, last_angle_in;
   logic               any_emit_ff, any_emit_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               kind_ff, kind_in;
   logic [ANGLE_W-1:0] angle_ff, angle_in;
   logic [DIST_W-1:0]  dist_ff, dist_in;
   logic               pvalid_ff, pvalid_in;
   logic               rev_ff, rev_in;
   logic               last_ff, last_in;

   logic               slot_free;
   logic [ANGLE_W-1:0] angle_wrapped;

   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         store_ff[store_wr.addr] <= store_wr.data;
      end
      dist_rd_ff <= store_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= EMIT_IDLE;
         rsp_valid_ff  <= 1'b0;
         last_angle_ff <= '0;
         any_emit_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_angle_ff <= last_angle_in;
         any_emit_ff   <= any_emit_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff      <= p_in;
      c_ff      <= c_in;
      d_ff      <= d_in;
      acc_ff    <= acc_in;
      idx_ff    <= idx_in;
      kind_ff   <= kind_in;
      angle_ff  <= angle_in;
      dist_ff   <= dist_in;
      pvalid_ff <= pvalid_in;
      rev_ff    <= rev_in;
      last_ff   <= last_in;
   end

   always_comb begin
      state_in      = state_ff;
      p_in          = p_ff;
      c_in          = c_ff;
      d_in          = d_ff;
      acc_in        = acc_ff;
      idx_in        = idx_ff;
      last_angle_in = last_angle_ff;
      any_emit_in   = any_emit_ff;
      kind_in       = kind_ff;
      angle_in      = angle_ff;
      dist_in       = dist_ff;
      pvalid_in     = pvalid_ff;
      rev_in        = rev_ff;
      last_in       = last_ff;
      rd_addr       = idx_ff;

      slot_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      angle_wrapped = (acc_ff > FULL_TURN_U) ? (acc_ff - FULL_TURN_U) : acc_ff;

      case (state_ff)
         EMIT_IDLE: begin
            if (emit_req.err) begin
               state_in = EMIT_ERR;
            end else if (emit_req.run) begin
               p_in     = emit_req.prev_angle;
               c_in     = emit_req.cur_angle;
               idx_in   = '0;
               state_in = EMIT_DIFF;
            end
         end
         EMIT_DIFF: begin
            // start-angle difference, wrapped once through a full turn
            if (p_ff <= c_ff) begin
               d_in = {1'b0, c_ff} - {1'b0, p_ff};
            end else begin
               d_in = FULL_TURN_Q6 + {1'b0, c_ff} - {1'b0, p_ff};
            end
            acc_in   = {1'b0, p_ff, {IDX_W{1'b0}}};
            state_in = EMIT_RUN;
         end
         EMIT_RUN: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               kind_in       = KIND_POINT;
               angle_in      = angle_wrapped;
               dist_in       = dist_rd_ff;
               pvalid_in     = (dist_rd_ff != '0);
               rev_in        = any_emit_ff && (last_angle_ff > HIGH_LIMIT_U)
                               && (angle_wrapped < LOW_LIMIT_U);
               last_in       = (idx_ff == LAST_IDX);
               last_angle_in = angle_wrapped;
               any_emit_in   = 1'b1;
               // difference goes negative for start angles past a full turn
               acc_in        = acc_ff + {{(ANGLE_W - DELTA_W){d_ff[DELTA_W-1]}}, d_ff};
               idx_in        = idx_ff + 1'b1;
               rd_addr       = idx_ff + 1'b1;
               if (idx_ff == LAST_IDX) begin
                  state_in = EMIT_IDLE;
               end
            end
         end
         EMIT_ERR: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_SYNC_ERR;
               angle_in     = '0;
               dist_in      = '0;
               pvalid_in    = 1'b0;
               rev_in       = 1'b0;
               last_in      = 1'b1;
               state_in     = EMIT_IDLE;
            end
         end
         default: begin
            state_in = EMIT_IDLE;
         end
      endcase
   end

   assign busy                 = (state_ff != EMIT_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_kind             = kind_ff;
   assign rsp_point_angle      = angle_ff;
   assign rsp_point_distance   = dist_ff;
   assign rsp_point_valid      = pvalid_ff;
   assign rsp_revolution_start = rev_ff;
   assign rsp_last_of_run      = last_ff;

endmodule

/* design/lidar_capsule_point_interpolator_core.sv */
// top level: capsule byte parser feeding the point emitter
// Bytes that cause no result are taken one per clock while the emitter
// sequencer is idle. A sync failure takes the byte, and the error word is then
// loaded into the result register. A byte that releases a capsule's points is
// followed by forming the start-angle difference, then by each point in turn
// through the single angle adder and the distance store's read port, 32 points
// in all; a stall on rsp_stall holds the sequence. The
// block holds req_stall high while the emitter sequencer is busy, and a
// finished word waits in the result register while the next byte is taken.
module lidar_capsule_point_interpolator_core
   import lcpi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [DATA_W-1:0]  req_data_byte,
   input  logic               req_capsule_start,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_kind,
   output logic [ANGLE_W-1:0] rsp_point_angle,
   output logic [DIST_W-1:0]  rsp_point_distance,
   output logic               rsp_point_valid,
   output logic               rsp_revolution_start,
   output logic               rsp_last_of_run
);

   logic [POS_W-1:0]     pos_ff, pos_in;
   logic                 discard_ff, discard_in;
   logic                 prev_valid_ff, prev_valid_in;
   logic [Q6_W-1:0]      prev_angle_ff, prev_angle_in;
   logic [Q6_W-1:0]      cur_angle_ff, cur_angle_in;
   logic [DATA_W-1:0]    held_ff, held_in;
   logic [CAB_POS_W-1:0] cab_j_ff, cab_j_in;
   logic [CAB_W-1:0]     cab_k_ff, cab_k_in;

   logic                 busy;
   logic                 go;
   logic                 advance;
   logic                 prev_valid_cur;
   logic [POS_W-1:0]     pos_cur;
   emit_req_type         emit_req;
   store_wr_type         store_wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         discard_ff    <= 1'b1;
         prev_valid_ff <= 1'b0;
         prev_angle_ff <= '0;
         cur_angle_ff  <= '0;
         held_ff       <= '0;
         cab_j_ff      <= '0;
         cab_k_ff      <= '0;
      end else begin
         pos_ff        <= pos_in;
         discard_ff    <= discard_in;
         prev_valid_ff <= prev_valid_in;
         prev_angle_ff <= prev_angle_in;
         cur_angle_ff  <= cur_angle_in;
         held_ff       <= held_in;
         cab_j_ff      <= cab_j_in;
         cab_k_ff      <= cab_k_in;
      end
   end

   always_comb begin
      pos_in         = pos_ff;
      discard_in     = discard_ff;
      prev_valid_in  = prev_valid_ff;
      prev_angle_in  = prev_angle_ff;
      cur_angle_in   = cur_angle_ff;
      held_in        = held_ff;
      cab_j_in       = cab_j_ff;
      cab_k_in       = cab_k_ff;
      emit_req       = '0;
      store_wr       = '0;
      go             = 1'b0;
      advance        = 1'b0;
      prev_valid_cur = prev_valid_ff;
      pos_cur        = pos_ff;

      if (req_valid && !req_stall) begin
         if (req_capsule_start) begin
            // capsule cut short
            if (!discard_ff && (pos_ff != '0)) begin
               prev_valid_cur = 1'b0;
            end
            pos_cur = '0;
            go      = 1'b1;
         end else begin
            go = !discard_ff;
         end
      end

      if (go) begin
         discard_in    = 1'b0;
         prev_valid_in = prev_valid_cur;
         advance       = 1'b1;
         case (pos_cur)
            POS_SYNC0, POS_ANGLE_LO: begin
               held_in = req_data_byte;
            end
            POS_SYNC1: begin
               if ((held_ff[7:4] != SYNC0_NIBBLE) || (req_data_byte[7:4] != SYNC1_NIBBLE)) begin
                  prev_valid_in = 1'b0;
                  discard_in    = 1'b1;
                  pos_in        = '0;
                  advance       = 1'b0;
                  emit_req.err  = 1'b1;
               end
            end
            POS_ANGLE_HI: begin
               cur_angle_in = {req_data_byte[6:0], held_ff};
               cab_j_in     = '0;
               cab_k_in     = '0;
               if (!req_data_byte[7] && prev_valid_ff) begin
                  emit_req.run        = 1'b1;
                  emit_req.prev_angle = prev_angle_ff;
                  emit_req.cur_angle  = {req_data_byte[6:0], held_ff};
               end
            end
            default: begin
               case (cab_j_ff)
                  CAB_DIST0_LO, CAB_DIST1_LO: begin
                     held_in = req_data_byte;
                  end
                  CAB_DIST0_HI: begin
                     store_wr.en   = 1'b1;
                     store_wr.addr = {cab_k_ff, 1'b0};
                     store_wr.data = {req_data_byte, held_ff[7:2]};
                  end
                  CAB_DIST1_HI: begin
                     store_wr.en   = 1'b1;
                     store_wr.addr = {cab_k_ff, 1'b1};
                     store_wr.data = {req_data_byte, held_ff[7:2]};
                  end
                  default: begin
                  end
               endcase
               if (cab_j_ff == CAB_COMP) begin
                  cab_j_in = '0;
                  cab_k_in = cab_k_ff + 1'b1;
               end else begin
                  cab_j_in = cab_j_ff + 1'b1;
               end
            end
         endcase

         if (advance) begin
            if (({1'b0, pos_cur} + 1'b1) >= (POS_W + 1)'(CAPSULE_BYTES)) begin
               prev_valid_in = 1'b1;
               prev_angle_in = cur_angle_ff;
               discard_in    = 1'b1;
               pos_in        = '0;
            end else begin
               pos_in = pos_cur + 1'b1;
            end
         end
      end
   end

   assign req_stall = busy;

   lcpi_emitter u_emitter (
      .clock                (clock),
      .reset                (reset),
      .emit_req             (emit_req),
      .store_wr             (store_wr),
      .busy                 (busy),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_kind             (rsp_kind),
      .rsp_point_angle      (rsp_point_angle),
      .rsp_point_distance   (rsp_point_distance),
      .rsp_point_valid      (rsp_point_valid),
      .rsp_revolution_start (rsp_revolution_start),
      .rsp_last_of_run      (rsp_last_of_run)
   );

endmodule

/* design/lcpi_checker.sv */
// port-level checks of the capsule point interpolator and their binding
module lcpi_checker
   import lcpi_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_kind,
   input logic [ANGLE_W-1:0] rsp_point_angle,
   input logic [DIST_W-1:0]  rsp_point_distance,
   input logic               rsp_point_valid,
   input logic               rsp_revolution_start,
   input logic               rsp_last_of_run
);

   // no word right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word present after reset");

   // a stalled word holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_point_angle) && $stable(rsp_point_distance)
         && $stable(rsp_last_of_run))
      else $error("stalled result word changed");

   // sync error word is all zero but its markers
   a_err_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_SYNC_ERR) |-> rsp_last_of_run
         && (rsp_point_angle == '0) && (rsp_point_distance == '0)
         && !rsp_point_valid && !rsp_revolution_start)
      else $error("malformed sync error word");

   // point valid follows nonzero distance
   a_point_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_POINT) |->
         (rsp_point_valid == (rsp_point_distance != '0)))
      else $error("point valid does not match distance");

   // revolution start only just past zero degrees
   a_rev_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_revolution_start |-> (rsp_point_angle < LOW_LIMIT_U))
      else $error("revolution start on a high angle");

endmodule

bind lidar_capsule_point_interpolator_core lcpi_checker u_lcpi_checker (.*);
